// ===== sv/ostid_pkg.sv =====
// ----------------------------------------------------------------------------
// ostid_pkg: shared types and constants of the ordered stream id table
// Widths, operation and status codes, entry and cell control structs.
// ----------------------------------------------------------------------------
package ostid_pkg;

  // table geometry
  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // field widths
  localparam int MODE_W     = 3;
  localparam int KEY_W      = 62;
  localparam int HANDLE_W   = 16;
  localparam int TAG_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int FCNT_W     = 7;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 104;

  // key classes counted by the table
  localparam logic [1:0] CLS_REQUEST = 2'd0;
  localparam logic [1:0] CLS_PUSH    = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_FIND   = 3'd1,
    MODE_SEARCH = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_NEXT   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RES  = 1'b1
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag;
  } probe_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/ostid_cell.sv =====
// ----------------------------------------------------------------------------
// ostid_cell: one slot of the ordered table
// Holds one entry, compares it against the probe and takes its neighbour's
// entry when the table closes a gap.
// ----------------------------------------------------------------------------
module ostid_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ostid_pkg::cell_ctrl_t ctrl_i,
  input  logic                 valid_i,
  input  ostid_pkg::probe_t    probe_i,
  input  ostid_pkg::entry_t    new_i,
  input  ostid_pkg::entry_t    next_i,
  output ostid_pkg::entry_t    entry_o,
  output logic                 match_o
);

  ostid_pkg::entry_t entry_q;
  logic              match_q;
  logic              match_d;
  logic              hit;

  // compare the stored entry with the probe word
  always_comb begin
    case (probe_i.mode) inside
      ostid_pkg::MODE_FIND, ostid_pkg::MODE_REMOVE: hit = (entry_q.key == probe_i.key);
      ostid_pkg::MODE_SEARCH:                       hit = (entry_q.tag == probe_i.tag);
      ostid_pkg::MODE_NEXT:                         hit = (entry_q.handle == probe_i.handle);
      default:                                      hit = 1'b0;
    endcase
    match_d = valid_i & hit;
  end

  // match flag, captured with the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      match_q <= match_d;
    end
  end

  // entry storage: append or move up from the neighbour
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= new_i;
    end else if (ctrl_i.shift) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== sv/ostid_select.sv =====
// ----------------------------------------------------------------------------
// ostid_select: first-match selection over the cell row
// Parallel prefix of the match flags, one-hot pick of the first or next
// entry and the mask of cells that move up on a removal.
// ----------------------------------------------------------------------------
module ostid_select (
  input  logic [ostid_pkg::DEPTH-1:0]     match_i,
  input  logic [ostid_pkg::DEPTH-1:0]     valid_i,
  input  ostid_pkg::entry_t               entries_i [ostid_pkg::DEPTH],
  input  logic [ostid_pkg::MODE_W-1:0]    mode_i,
  input  logic                            prev_present_i,
  output logic                            hit_o,
  output ostid_pkg::entry_t               sel_o,
  output logic [ostid_pkg::DEPTH-1:0]     shift_mask_o
);

  logic [ostid_pkg::DEPTH-1:0] seen [ostid_pkg::IDX_W+1];
  logic [ostid_pkg::DEPTH-1:0] first;
  logic [ostid_pkg::DEPTH-1:0] pick;

  // log-depth prefix or: seen[i] is set at and after the first match
  always_comb begin
    seen[0] = match_i;
    for (int l = 0; l < ostid_pkg::IDX_W; l++) begin
      for (int i = 0; i < ostid_pkg::DEPTH; i++) begin
        if (i >= (1 << l)) begin
          seen[l+1][i] = seen[l][i] | seen[l][i-(1 << l)];
        end else begin
          seen[l+1][i] = seen[l][i];
        end
      end
    end
  end

  // one-hot of the first match, then of the entry to return
  always_comb begin
    first = seen[ostid_pkg::IDX_W] & ~{seen[ostid_pkg::IDX_W][ostid_pkg::DEPTH-2:0], 1'b0};
    pick  = '0;
    if (mode_i == ostid_pkg::MODE_NEXT) begin
      if (prev_present_i) begin
        pick = {first[ostid_pkg::DEPTH-2:0], 1'b0} & valid_i;
      end else begin
        pick[0] = valid_i[0];
      end
    end else begin
      pick = first;
    end
  end

  // and-or mux of the picked entry
  always_comb begin
    sel_o = '0;
    for (int i = 0; i < ostid_pkg::DEPTH; i++) begin
      sel_o = sel_o | (entries_i[i] & {$bits(ostid_pkg::entry_t){pick[i]}});
    end
  end

  assign hit_o        = |pick;
  assign shift_mask_o = seen[ostid_pkg::IDX_W];

endmodule

// ===== sv/ordered_stream_id_table.sv =====
// No new input word is taken until the last one's result is registered. The
// idle state takes the word and captures the match flags of all cells; the
// result state picks the entry and updates the row. A result waiting on the
// master side holds the row until it is taken.
// Reset (rst_ni low, asynchronous) empties the table and clears all counts;
// stored entries are not cleared, the fill count marks what is valid.
// ----------------------------------------------------------------------------
// ordered_stream_id_table: insertion-ordered stream table
// Row of cells with add, find, search, remove with gap closing and next-after.
// ----------------------------------------------------------------------------
module ordered_stream_id_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // key[61:0], handle[77:62], tag[109:78], prev_present[110], zero pad
  input  logic [ostid_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // mode[2:0]
  input  logic [ostid_pkg::MODE_W-1:0]        s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // found_key[61:0], found_handle[77:62], request_count[84:78],
  // push_count[91:85], occupancy[98:92], zero pad
  output logic [ostid_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // status[1:0]
  output logic [ostid_pkg::STATUS_W-1:0]      m_axis_tuser_o
);

  localparam int DEPTH = ostid_pkg::DEPTH;
  localparam int CNT_W = ostid_pkg::CNT_W;

  ostid_pkg::state_e state_q, state_d;

  logic [ostid_pkg::MODE_W-1:0] mode_q;
  logic                         prev_q;
  ostid_pkg::entry_t            new_q;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             req_q, req_d;
  logic [CNT_W-1:0]             push_q, push_d;

  logic                         out_valid_q;
  logic [ostid_pkg::STATUS_W-1:0] out_status_q;
  logic [ostid_pkg::KEY_W-1:0]    out_key_q;
  logic [ostid_pkg::HANDLE_W-1:0] out_handle_q;
  logic [ostid_pkg::FCNT_W-1:0]   out_req_q, out_push_q, out_occ_q;

  logic s_fire, advance, commit;
  logic add_ok, remove_ok, hit;
  logic [ostid_pkg::STATUS_W-1:0] status_d;

  ostid_pkg::probe_t  probe;
  ostid_pkg::entry_t  entries [DEPTH];
  ostid_pkg::entry_t  sel;
  logic [DEPTH-1:0]   match, valid, shift_mask;

  // input word unpacked into the probe
  assign probe.mode   = s_axis_tuser_i;
  assign probe.key    = s_axis_tdata_i[61:0];
  assign probe.handle = s_axis_tdata_i[77:62];
  assign probe.tag    = s_axis_tdata_i[109:78];

  assign s_fire  = s_axis_tvalid_i & s_axis_tready_o;
  assign advance = ~out_valid_q | m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ostid_pkg::S_IDLE: if (s_fire) state_d = ostid_pkg::S_RES;
      ostid_pkg::S_RES:  if (advance) state_d = ostid_pkg::S_IDLE;
      default:           state_d = ostid_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    commit          = 1'b0;
    unique case (state_q)
      ostid_pkg::S_IDLE: s_axis_tready_o = 1'b1;
      ostid_pkg::S_RES:  commit = advance;
      default: begin
        s_axis_tready_o = 1'b0;
        commit          = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ostid_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // operation word held for the result cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ostid_pkg::MODE_ADD;
      prev_q <= 1'b0;
    end else if (s_fire) begin
      mode_q <= s_axis_tuser_i;
      prev_q <= s_axis_tdata_i[110];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      new_q.key    <= probe.key;
      new_q.handle <= probe.handle;
      new_q.tag    <= probe.tag;
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ostid_pkg::cell_ctrl_t ctrl;
    ostid_pkg::entry_t     next_entry;

    assign valid[i]     = (CNT_W'(i) < count_q);
    assign ctrl.capture = s_fire;
    assign ctrl.load    = commit & add_ok & (count_q == CNT_W'(i));
    assign ctrl.shift   = commit & remove_ok & shift_mask[i];

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = entries[i];
    end else begin : g_mid
      assign next_entry = entries[i+1];
    end

    ostid_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .valid_i (valid[i]),
      .probe_i (probe),
      .new_i   (new_q),
      .next_i  (next_entry),
      .entry_o (entries[i]),
      .match_o (match[i])
    );
  end

  ostid_select u_select (
    .match_i        (match),
    .valid_i        (valid),
    .entries_i      (entries),
    .mode_i         (mode_q),
    .prev_present_i (prev_q),
    .hit_o          (hit),
    .sel_o          (sel),
    .shift_mask_o   (shift_mask)
  );

  // status and count updates
  always_comb begin
    add_ok    = (mode_q == ostid_pkg::MODE_ADD) && (count_q < CNT_W'(DEPTH));
    remove_ok = (mode_q == ostid_pkg::MODE_REMOVE) && hit;
    count_d   = count_q;
    req_d     = req_q;
    push_d    = push_q;
    case (mode_q) inside
      ostid_pkg::MODE_ADD: begin
        status_d = add_ok ? ostid_pkg::STATUS_OK : ostid_pkg::STATUS_FULL;
      end
      ostid_pkg::MODE_FIND, ostid_pkg::MODE_SEARCH,
      ostid_pkg::MODE_REMOVE, ostid_pkg::MODE_NEXT: begin
        status_d = hit ? ostid_pkg::STATUS_OK : ostid_pkg::STATUS_MISS;
      end
      default: status_d = ostid_pkg::STATUS_MISS;
    endcase
    if (add_ok) begin
      count_d = count_q + 1'b1;
      if (new_q.key[1:0] == ostid_pkg::CLS_REQUEST) req_d  = req_q + 1'b1;
      if (new_q.key[1:0] == ostid_pkg::CLS_PUSH)    push_d = push_q + 1'b1;
    end else if (remove_ok) begin
      count_d = count_q - 1'b1;
      if ((sel.key[1:0] == ostid_pkg::CLS_REQUEST) && (req_q != '0)) req_d = req_q - 1'b1;
      if ((sel.key[1:0] == ostid_pkg::CLS_PUSH) && (push_q != '0))  push_d = push_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      req_q   <= '0;
      push_q  <= '0;
    end else if (commit) begin
      count_q <= count_d;
      req_q   <= req_d;
      push_q  <= push_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_status_q <= status_d;
      out_key_q    <= sel.key;
      out_handle_q <= sel.handle;
      out_req_q    <= ostid_pkg::FCNT_W'(req_d);
      out_push_q   <= ostid_pkg::FCNT_W'(push_d);
      out_occ_q    <= ostid_pkg::FCNT_W'(count_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {5'b0, out_occ_q, out_push_q, out_req_q, out_handle_q, out_key_q};

endmodule

// ===== sv/ostid_checker.sv =====
// ----------------------------------------------------------------------------
// ostid_checker: port-level checks of the ordered stream id table
// Watches both stream sides and the result word over time.
// ----------------------------------------------------------------------------
module ostid_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [ostid_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [ostid_pkg::STATUS_W-1:0]   m_axis_tuser_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // one word in flight: no new word taken right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken on consecutive cycles");

  // occupancy never exceeds the table depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[98:92] <= ostid_pkg::FCNT_W'(ostid_pkg::DEPTH))
    else $error("occupancy above depth");

  // full status only with a full table
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ostid_pkg::STATUS_FULL) |->
      m_axis_tdata_o[98:92] == ostid_pkg::FCNT_W'(ostid_pkg::DEPTH))
    else $error("full status with free slots");

  // a miss returns no key and no handle
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ostid_pkg::STATUS_MISS) |->
      (m_axis_tdata_o[77:0] == '0))
    else $error("miss with non-zero found fields");

endmodule

bind ordered_stream_id_table ostid_checker u_ostid_checker (.*);
